// ===== rtl/scct_pkg.sv =====
package scct_pkg;

    localparam int COORD_BITS_DEF = 15;
    localparam int CFG_IDX_BITS   = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS   = 2'd2
    } t_cfg_reg;

    // load enables for the two stages of the squared-distance compare
    typedef struct packed {
        logic s5;
        logic s6;
    } t_cmp_adv;

endpackage

// ===== rtl/segment_circle_crossing_test_unit.sv =====
// Segment vs circle crossing test, fully pipelined.
// Seven register stages; a stall at the output holds every full stage behind it.
// Throughput: one segment per cycle while m_axis_tready is high; stages advance independently, bubbles collapse.
// The widest path is the split squaring of the cross product (half-width multipliers).
// Reset (synchronous, active low) clears valid bits and sets center and radius to 0.
module segment_circle_crossing_test_unit #(
    parameter int COORD_BITS = scct_pkg::COORD_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_wr_en,
    input  logic [scct_pkg::CFG_IDX_BITS-1:0]         i_cfg_addr,
    input  logic [COORD_BITS-1:0]                     i_cfg_wdata,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // start_x, start_y, end_x, end_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // crosses, zero pad
    output logic [7:0]                                m_axis_tdata
);

    localparam int W  = COORD_BITS;
    localparam int D  = W + 1;
    localparam int P  = 2 * D;
    localparam int CS = 2 * D + 1;
    localparam int CM = 2 * W + 2;
    localparam int SQ = 2 * W;
    localparam int L2 = 2 * W + 1;
    localparam int RW = 2 * W - 2;
    localparam int LW = 4 * W + 4;

    // config
    logic signed [W-1:0] r_center_x;
    logic signed [W-1:0] r_center_y;
    logic [W-2:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
        end else if (i_cfg_wr_en) begin
            case (scct_pkg::t_cfg_reg'(i_cfg_addr))
                scct_pkg::REG_CENTER_X: r_center_x <= i_cfg_wdata;
                scct_pkg::REG_CENTER_Y: r_center_y <= i_cfg_wdata;
                scct_pkg::REG_RADIUS:   r_radius   <= i_cfg_wdata[W-2:0];
                default: ;
            endcase
        end
    end

    // stage control
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_vo;
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6, w_eno;
    scct_pkg::t_cmp_adv w_adv;

    assign w_eno = !r_vo || m_axis_tready;
    assign w_en6 = !r_v6 || w_eno;
    assign w_en5 = !r_v5 || w_en6;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign w_adv.s5 = w_en5;
    assign w_adv.s6 = w_en6;

    assign s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
            if (w_en6) r_v6 <= r_v5;
            if (w_eno) r_vo <= r_v6;
        end
    end

    // stage 1: differences
    logic signed [W-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [D-1:0] r_abx, r_aby, r_acx, r_acy, r_bcx, r_bcy;

    assign w_ax = s_axis_tdata[W-1:0];
    assign w_ay = s_axis_tdata[2*W-1:W];
    assign w_bx = s_axis_tdata[3*W-1:2*W];
    assign w_by = s_axis_tdata[4*W-1:3*W];

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_abx <= D'(w_bx) - D'(w_ax);
            r_aby <= D'(w_by) - D'(w_ay);
            r_acx <= D'(r_center_x) - D'(w_ax);
            r_acy <= D'(r_center_y) - D'(w_ay);
            r_bcx <= D'(r_center_x) - D'(w_bx);
            r_bcy <= D'(r_center_y) - D'(w_by);
        end
    end

    // stage 2: products
    logic signed [P-1:0] n_cx1, n_cx2, n_s1a, n_s1b, n_s2a, n_s2b;
    logic signed [P-1:0] n_qabx, n_qaby, n_qacx, n_qacy, n_qbcx, n_qbcy;
    logic signed [P-1:0] r_cx1, r_cx2, r_s1a, r_s1b, r_s2a, r_s2b;
    logic [SQ-1:0]       r_qabx, r_qaby, r_qacx, r_qacy, r_qbcx, r_qbcy;
    logic [RW-1:0]       r_r2_2;

    always_comb begin
        n_cx1  = r_abx * r_acy;
        n_cx2  = r_aby * r_acx;
        n_s1a  = r_abx * r_acx;
        n_s1b  = r_aby * r_acy;
        n_s2a  = r_abx * r_bcx;
        n_s2b  = r_aby * r_bcy;
        n_qabx = r_abx * r_abx;
        n_qaby = r_aby * r_aby;
        n_qacx = r_acx * r_acx;
        n_qacy = r_acy * r_acy;
        n_qbcx = r_bcx * r_bcx;
        n_qbcy = r_bcy * r_bcy;
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_cx1  <= n_cx1;
            r_cx2  <= n_cx2;
            r_s1a  <= n_s1a;
            r_s1b  <= n_s1b;
            r_s2a  <= n_s2a;
            r_s2b  <= n_s2b;
            r_qabx <= n_qabx[SQ-1:0];
            r_qaby <= n_qaby[SQ-1:0];
            r_qacx <= n_qacx[SQ-1:0];
            r_qacy <= n_qacy[SQ-1:0];
            r_qbcx <= n_qbcx[SQ-1:0];
            r_qbcy <= n_qbcy[SQ-1:0];
            r_r2_2 <= r_radius * r_radius;
        end
    end

    // stage 3: sums
    logic signed [CS-1:0] r_cross, r_s1, r_t2;
    logic [L2-1:0]        r_len2_3, r_da, r_db;
    logic [RW-1:0]        r_r2_3;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_cross  <= CS'(r_cx1) - CS'(r_cx2);
            r_s1     <= CS'(r_s1a) + CS'(r_s1b);
            r_t2     <= CS'(r_s2a) + CS'(r_s2b);
            r_len2_3 <= L2'(r_qabx) + L2'(r_qaby);
            r_da     <= L2'(r_qacx) + L2'(r_qacy);
            r_db     <= L2'(r_qbcx) + L2'(r_qbcy);
            r_r2_3   <= r_r2_2;
        end
    end

    // stage 4: magnitude, inside and projection tests
    logic signed [CS-1:0] w_neg_cross;
    logic [CM-1:0]        n_cr_mag;
    logic                 n_hit;
    logic                 n_ok;
    logic [CM-1:0]        r_cr_mag;
    logic [L2-1:0]        r_len2_4;
    logic [RW-1:0]        r_r2_4;
    logic                 r_ok4, r_ok5, r_ok6;

    always_comb begin
        w_neg_cross = -r_cross;
        n_cr_mag    = r_cross[CS-1] ? w_neg_cross[CM-1:0] : r_cross[CM-1:0];
        // s2 = -t2, so s2 >= 0 means t2 <= 0
        n_hit = (r_da < L2'(r_r2_3)) || (r_db < L2'(r_r2_3))
             || (!r_s1[CS-1] && (r_t2[CS-1] || (r_t2 == '0)));
        n_ok  = n_hit && (r_len2_3 != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_cr_mag <= n_cr_mag;
            r_len2_4 <= r_len2_3;
            r_r2_4   <= r_r2_3;
            r_ok4    <= n_ok;
        end
    end

    // stages 5 and 6: line distance compare
    logic [LW-1:0] w_lhs, w_rhs;

    scct_sq_cmp #(
        .COORD_BITS (COORD_BITS)
    ) u_sq_cmp (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_cr_mag (r_cr_mag),
        .i_len2   (r_len2_4),
        .i_r2     (r_r2_4),
        .o_lhs    (w_lhs),
        .o_rhs    (w_rhs)
    );

    always_ff @(posedge i_clk) begin
        if (w_en5) r_ok5 <= r_ok4;
        if (w_en6) r_ok6 <= r_ok5;
    end

    // output register
    logic r_crosses;

    always_ff @(posedge i_clk) begin
        if (w_eno) r_crosses <= r_ok6 && (w_lhs < w_rhs);
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {7'b0, r_crosses};

endmodule

// ===== rtl/scct_sq_cmp.sv =====
// cross^2 vs r^2 * len^2, split into half-width partial products
module scct_sq_cmp #(
    parameter int COORD_BITS = scct_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  scct_pkg::t_cmp_adv        i_adv,
    input  logic [2*COORD_BITS+1:0]   i_cr_mag,
    input  logic [2*COORD_BITS:0]     i_len2,
    input  logic [2*COORD_BITS-3:0]   i_r2,
    output logic [4*COORD_BITS+3:0]   o_lhs,
    output logic [4*COORD_BITS+3:0]   o_rhs
);

    localparam int H  = COORD_BITS + 1;
    localparam int LW = 4 * H;
    localparam int RW = 2 * COORD_BITS - 2;

    logic [H-1:0]    w_ch;
    logic [H-1:0]    w_cl;
    logic [2*H-1:0]  w_len2x;
    logic [H-1:0]    w_lh;
    logic [H-1:0]    w_ll;

    logic [2*H-1:0]  r_chh;
    logic [2*H-1:0]  r_chl;
    logic [2*H-1:0]  r_cll;
    logic [RW+H-1:0] r_rlh;
    logic [RW+H-1:0] r_rll;

    logic [LW-1:0]   n_lhs;
    logic [LW-1:0]   n_rhs;
    logic [LW-1:0]   r_lhs;
    logic [LW-1:0]   r_rhs;

    assign w_ch    = i_cr_mag[2*H-1:H];
    assign w_cl    = i_cr_mag[H-1:0];
    assign w_len2x = (2*H)'(i_len2);
    assign w_lh    = w_len2x[2*H-1:H];
    assign w_ll    = w_len2x[H-1:0];

    always_ff @(posedge i_clk) begin
        if (i_adv.s5) begin
            r_chh <= w_ch * w_ch;
            r_chl <= w_ch * w_cl;
            r_cll <= w_cl * w_cl;
            r_rlh <= i_r2 * w_lh;
            r_rll <= i_r2 * w_ll;
        end
    end

    // ch^2 and cl^2 do not overlap, so they concatenate
    always_comb begin
        n_lhs = {r_chh, r_cll} + (LW'(r_chl) << (H + 1));
        n_rhs = (LW'(r_rlh) << H) + LW'(r_rll);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s6) begin
            r_lhs <= n_lhs;
            r_rhs <= n_rhs;
        end
    end

    assign o_lhs = r_lhs;
    assign o_rhs = r_rhs;

endmodule
